FILE: rtl/irmu_pkg.sv
`timescale 1ns / 1ps

package irmu_pkg;

   // memory size and derived widths
   localparam int MEM_BYTES = 4096;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int LIMIT_W   = 17;

   // request codes
   typedef enum logic [3:0] {
      OP_SET_INDEX = 4'd0,
      OP_ADD_REG   = 4'd1,
      OP_FONT_ADDR = 4'd2,
      OP_BCD       = 4'd3,
      OP_STORE     = 4'd4,
      OP_LOAD      = 4'd5,
      OP_WR_REG    = 4'd6,
      OP_WR_MEM    = 4'd7,
      OP_RD_REG    = 4'd8,
      OP_RD_MEM    = 4'd9
   } op_type;

   // input transaction
   typedef struct packed {
      logic [3:0]  req_type;
      logic [3:0]  reg_sel;
      logic [11:0] literal_addr;
      logic [7:0]  byte_value;
   } req_item_type;

   // result transaction
   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] index_value;
      logic        error;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       exec;
      logic       bcd_step;
      logic       store_step;
      logic       load_step;
      logic       rsp_load;
      logic [4:0] cnt;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] op;
      logic [3:0] x;
      logic       err;
   } status_type;

endpackage

FILE: rtl/index_register_memory_unit.sv
`timescale 1ns / 1ps
// sequence: capture, execute, then one step per bcd digit, stored byte or loaded
//    byte (load has one extra step), then finish registers the result
// throughput: one transaction at a time, the next is accepted once the result
//    is registered; block moves take one single-port memory cycle per byte
// reset: synchronous, clears index, byte registers and control; memory is not cleared
module index_register_memory_unit import irmu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   irmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, memory and arithmetic
   irmu_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // one transaction at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("transaction accepted while another is in progress");

   // result only from the sequencer's finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("result raised without a load command");

   // load counter stays within the block
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.load_step |-> (cmd.cnt <= ({1'b0, status.x} + 5'd1)))
      else $error("block load counter past last register");

endmodule

FILE: rtl/irmu_ctrl.sv
`timescale 1ns / 1ps

module irmu_ctrl import irmu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_BCD   = 6'b000100,
      ST_STORE = 6'b001000,
      ST_LOAD  = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd            = '0;
      cmd.cnt        = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cnt_in   = '0;
            if (status.err) begin
               state_in = ST_FIN;
            end else begin
               case (status.op)
                  OP_BCD:   state_in = ST_BCD;
                  OP_STORE: state_in = ST_STORE;
                  OP_LOAD:  state_in = ST_LOAD;
                  default:  state_in = ST_FIN;
               endcase
            end
         end
         ST_BCD: begin
            cmd.bcd_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'd2) begin
               state_in = ST_FIN;
            end
         end
         ST_STORE: begin
            cmd.store_step = 1'b1;
            cnt_in         = cnt_ff + 5'd1;
            if (cnt_ff == {1'b0, status.x}) begin
               state_in = ST_FIN;
            end
         end
         ST_LOAD: begin
            // each register write takes the byte read in the step before
            cmd.load_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == ({1'b0, status.x} + 5'd1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/irmu_datapath.sv
`timescale 1ns / 1ps

module irmu_datapath import irmu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  cmd_type      cmd,
   output status_type   status,
   output rsp_item_type rsp_item
);

   logic [3:0]        op_ff;
   logic [3:0]        x_ff;
   logic [11:0]       addr_ff;
   logic [7:0]        val_ff;
   logic [15:0]       idx_ff, idx_in;
   logic [7:0]        breg_ff [16];
   logic [7:0]        rd_ff, rd_in;
   logic              rdmem_ff;
   logic              err_ff;
   logic [7:0]        mem [MEM_BYTES];
   logic [7:0]        mem_rd_ff;
   rsp_item_type      rsp_ff;

   logic [3:0]        rsel;
   logic [7:0]        breg_rd;
   logic [LIMIT_W-1:0] end_bcd;
   logic [LIMIT_W-1:0] end_move;
   logic              err_now;
   logic [MEM_AW-1:0] mem_addr;
   logic              mem_we;
   logic              mem_re;
   logic [7:0]        mem_wd;
   logic [3:0]        load_idx;

   // one decimal digit of a byte: hundreds, tens or units
   function automatic logic [3:0] bcd_digit(input logic [7:0] v, input logic [1:0] pos);
      logic [1:0]  h;
      logic [7:0]  r8;
      logic [6:0]  r;
      logic [14:0] prod;
      logic [3:0]  t;
      logic [6:0]  u;
      h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
      r8   = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
      r    = r8[6:0];
      prod = 15'(r) * 15'd205;
      t    = prod[14:11];
      u    = r - 7'(t) * 7'd10;
      case (pos)
         2'd0:    bcd_digit = {2'b00, h};
         2'd1:    bcd_digit = t;
         default: bcd_digit = u[3:0];
      endcase
   endfunction

   // single byte register read port
   assign rsel    = (cmd.store_step) ? cmd.cnt[3:0] : x_ff;
   assign breg_rd = breg_ff[rsel];

   // memory end checks
   assign end_bcd  = {1'b0, idx_ff} + LIMIT_W'(2);
   assign end_move = {1'b0, idx_ff} + LIMIT_W'(x_ff);
   always_comb begin
      case (op_ff)
         OP_BCD:            err_now = (end_bcd >= LIMIT_W'(MEM_BYTES));
         OP_STORE, OP_LOAD: err_now = (end_move >= LIMIT_W'(MEM_BYTES));
         default:           err_now = 1'b0;
      endcase
   end

   assign status.op  = op_ff;
   assign status.x   = x_ff;
   assign status.err = err_now;

   // memory port control
   assign load_idx = 4'(cmd.cnt - 5'd1);
   always_comb begin
      mem_addr = MEM_AW'({1'b0, idx_ff} + LIMIT_W'(cmd.cnt));
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_wd   = breg_rd;
      if (cmd.exec) begin
         mem_addr = MEM_AW'(addr_ff);
         mem_we   = (op_ff == OP_WR_MEM);
         mem_re   = (op_ff == OP_RD_MEM);
         mem_wd   = val_ff;
      end else if (cmd.bcd_step) begin
         mem_we = 1'b1;
         mem_wd = {4'b0000, bcd_digit(breg_rd, cmd.cnt[1:0])};
      end else if (cmd.store_step) begin
         mem_we = 1'b1;
      end else if (cmd.load_step) begin
         mem_re = (cmd.cnt <= {1'b0, x_ff});
      end
   end

   // main memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_addr];
      end
   end

   // index register update
   always_comb begin
      idx_in = idx_ff;
      rd_in  = 8'd0;
      if (cmd.exec) begin
         case (op_ff)
            OP_SET_INDEX: idx_in = 16'(addr_ff);
            OP_ADD_REG:   idx_in = idx_ff + 16'(breg_rd);
            OP_FONT_ADDR: idx_in = 16'({breg_rd, 2'b00}) + 16'(breg_rd);
            OP_RD_REG:    rd_in  = breg_rd;
            default:      idx_in = idx_ff;
         endcase
      end
   end

   // request capture and per-request flags
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_item.req_type;
         x_ff    <= req_item.reg_sel;
         addr_ff <= req_item.literal_addr;
         val_ff  <= req_item.byte_value;
      end
      if (cmd.exec) begin
         rd_ff    <= rd_in;
         rdmem_ff <= (op_ff == OP_RD_MEM);
         err_ff   <= err_now;
      end
   end

   // architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int i = 0; i < 16; i++) begin
            breg_ff[i] <= '0;
         end
      end else begin
         idx_ff <= idx_in;
         if (cmd.exec && (op_ff == OP_WR_REG)) begin
            breg_ff[x_ff] <= val_ff;
         end else if (cmd.load_step && (cmd.cnt != 5'd0)) begin
            breg_ff[load_idx] <= mem_rd_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.read_data   <= rdmem_ff ? mem_rd_ff : rd_ff;
         rsp_ff.index_value <= idx_ff;
         rsp_ff.error       <= err_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

FILE: test/irmu_result_checker.sv
`timescale 1ns / 1ps

module irmu_result_checker import irmu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_item,
   input  logic         drain_done,
   output int           failures
);

   localparam int GLYPH_BYTES = 5;
   localparam int RADIX       = 10;
   localparam int BCD_DIGITS  = 3;

   // predicted machine state
   logic [15:0]  idx_q;
   logic [7:0]   regs_q [16];
   logic [7:0]   mem_q [MEM_BYTES];
   rsp_item_type expected_results [$];
   bit           leftovers_checked = 1'b0;

   initial failures = 0;

   // apply one request to the predicted state and form its result
   function automatic rsp_item_type execute_request(input req_item_type r);
      rsp_item_type res;
      int unsigned  base;
      int unsigned  x;
      int unsigned  v;
      res  = '0;
      base = idx_q;
      x    = r.reg_sel;
      v    = regs_q[x];
      case (r.req_type)
         OP_SET_INDEX: idx_q = 16'(r.literal_addr);
         OP_ADD_REG:   idx_q = idx_q + 16'(v);
         OP_FONT_ADDR: idx_q = 16'(v * GLYPH_BYTES);
         OP_BCD: begin
            // all three digits must fit below the memory end
            if (base + BCD_DIGITS > MEM_BYTES) begin
               res.error = 1'b1;
            end else begin
               mem_q[base]     = 8'(v / (RADIX * RADIX));
               mem_q[base + 1] = 8'((v / RADIX) % RADIX);
               mem_q[base + 2] = 8'(v % RADIX);
            end
         end
         OP_STORE, OP_LOAD: begin
            if (base + x >= MEM_BYTES) begin
               res.error = 1'b1;
            end else begin
               for (int k = 0; k <= x; k++) begin
                  if (r.req_type == OP_STORE) mem_q[base + k] = regs_q[k];
                  else regs_q[k] = mem_q[base + k];
               end
            end
         end
         OP_WR_REG: regs_q[x] = r.byte_value;
         OP_WR_MEM: mem_q[r.literal_addr] = r.byte_value;
         OP_RD_REG: res.read_data = 8'(v);
         OP_RD_MEM: res.read_data = mem_q[r.literal_addr];
         default: ;
      endcase
      res.index_value = idx_q;
      return res;
   endfunction

   // compare results in order, then queue the prediction for each new transaction
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         idx_q = '0;
         foreach (regs_q[i]) regs_q[i] = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result with no transaction pending, index_value %0h",
                      rsp_item.index_value);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.read_data !== want.read_data) begin
                  $error("read_data expected %0h actual %0h",
                         want.read_data, rsp_item.read_data);
                  failures++;
               end
               if (rsp_item.index_value !== want.index_value) begin
                  $error("index_value expected %0h actual %0h",
                         want.index_value, rsp_item.index_value);
                  failures++;
               end
               if (rsp_item.error !== want.error) begin
                  $error("error expected %0b actual %0b", want.error, rsp_item.error);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) expected_results.push_back(execute_request(req_item));
         // anything still queued once the run has drained never came back
         if (drain_done && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (expected_results.size() != 0) begin
               $error("%0d results never arrived", expected_results.size());
               failures += expected_results.size();
            end
         end
      end
   end

endmodule

FILE: test/tb_index_register_memory_unit.sv
`timescale 1ns / 1ps

module tb_index_register_memory_unit;
   import irmu_pkg::*;

   localparam int         ITEM_TARGET      = 1450;
   localparam int         TAIL_ITEMS       = 150;
   localparam int         SETTLE_CYCLES    = 30;
   localparam int         CYCLE_LIMIT      = 600000;
   localparam int         CLIMB_ADDS       = 241;
   localparam int         BCD_DIGITS       = 3;
   localparam logic [3:0] FIRST_SPARE_CODE = 4'd10;
   localparam logic [3:0] LAST_SPARE_CODE  = 4'd15;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_valid  = 1'b0;
   logic         req_stall;
   req_item_type req_item   = '0;
   logic         rsp_valid;
   logic         rsp_stall  = 1'b0;
   rsp_item_type rsp_item;
   logic         idle_off   = 1'b0;
   logic         drain_done = 1'b0;
   int           failures;
   int           issued     = 0;

   always #4 clock = ~clock;

   index_register_memory_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   irmu_result_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .drain_done (drain_done),
      .failures   (failures)
   );

   // track which memory bytes are known written, so no unwritten byte is ever read
   req_item_type in_flight [$];
   bit           mem_written [MEM_BYTES];
   logic [15:0]  last_index     = '0;
   int           accepted_count = 0;
   int           returned_count = 0;
   int           range_errors   = 0;

   always @(posedge clock) begin
      req_item_type finished_req;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            in_flight.push_back(req_item);
            accepted_count <= accepted_count + 1;
         end
         if (rsp_valid && !rsp_stall && in_flight.size() != 0) begin
            finished_req = in_flight.pop_front();
            returned_count <= returned_count + 1;
            last_index     <= rsp_item.index_value;
            if (rsp_item.error) begin
               range_errors <= range_errors + 1;
            end else begin
               case (finished_req.req_type)
                  OP_BCD:
                     for (int k = 0; k < BCD_DIGITS; k++)
                        mem_written[rsp_item.index_value + k] <= 1'b1;
                  OP_STORE:
                     for (int k = 0; k <= finished_req.reg_sel; k++)
                        mem_written[rsp_item.index_value + k] <= 1'b1;
                  OP_WR_MEM: mem_written[finished_req.literal_addr] <= 1'b1;
                  default: ;
               endcase
            end
         end
      end
   end

   // random result side stalls, in bursts
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset || idle_off) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // run limit
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [3:0] any_reg();
      return 4'($urandom);
   endfunction

   function automatic logic [11:0] any_addr();
      return 12'($urandom);
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom);
   endfunction

   // index start, often close to the memory end
   function automatic logic [11:0] pick_index();
      if ($urandom_range(0, 3) == 0)
         return 12'($urandom_range(MEM_BYTES - 20, MEM_BYTES - 1));
      return any_addr();
   endfunction

   // present one transaction, with an occasional gap ahead of it
   task automatic issue(input logic [3:0] code, input logic [3:0] x,
                        input logic [11:0] addr, input logic [7:0] value);
      req_item_type item;
      item.req_type     = code;
      item.reg_sel      = x;
      item.literal_addr = addr;
      item.byte_value   = value;
      if (!idle_off && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      issued++;
   endtask

   // hold off until every accepted transaction has its result
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (returned_count != accepted_count) @(posedge clock);
   endtask

   // load regs only over written bytes; store first where needed
   task automatic load_regs(input logic [3:0] x);
      int unsigned base;
      bit          ready;
      wait_for_results();
      base  = last_index;
      ready = 1'b1;
      if (base + x < MEM_BYTES)
         for (int k = 0; k <= x; k++)
            if (!mem_written[base + k]) ready = 1'b0;
      if (!ready) begin
         issue(OP_STORE, x, any_addr(), any_byte());
         wait_for_results();
      end
      issue(OP_LOAD, x, any_addr(), any_byte());
   endtask

   // read some written byte, or write one if none is known yet
   task automatic read_mem();
      int start;
      int found;
      start = $urandom_range(0, MEM_BYTES - 1);
      found = -1;
      for (int k = 0; k < MEM_BYTES && found < 0; k++)
         if (mem_written[(start + k) % MEM_BYTES]) found = (start + k) % MEM_BYTES;
      if (found < 0) issue(OP_WR_MEM, any_reg(), any_addr(), any_byte());
      else issue(OP_RD_MEM, any_reg(), 12'(found), any_byte());
   endtask

   // walk the index past the memory end and around the 16-bit wrap
   task automatic climb_index();
      logic [3:0] x;
      x = any_reg();
      issue(OP_WR_REG, x, any_addr(), 8'hFF);
      issue(OP_SET_INDEX, any_reg(), 12'(MEM_BYTES - 1), any_byte());
      for (int n = 0; n < CLIMB_ADDS; n++) begin
         issue(OP_ADD_REG, x, any_addr(), any_byte());
         if (n % 40 == 20)
            issue($urandom_range(0, 1) ? OP_BCD : OP_STORE, any_reg(), any_addr(), any_byte());
      end
      issue(OP_RD_REG, x, any_addr(), any_byte());
      issue(OP_STORE, any_reg(), any_addr(), any_byte());
   endtask

   initial begin
      logic [3:0] x;
      logic [3:0] code;
      bit         climbed;
      climbed = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, range limits of bcd and block moves, spare codes
      issue(OP_RD_REG, 4'hF, 12'h000, 8'h00);
      issue(OP_WR_REG, 4'h0, 12'hFFF, 8'hFF);
      issue(OP_WR_REG, 4'hF, 12'h000, 8'h80);
      issue(OP_RD_REG, 4'h0, 12'h000, 8'h00);
      issue(OP_WR_MEM, 4'h0, 12'hFFF, 8'h5A);
      issue(OP_WR_MEM, 4'hF, 12'h000, 8'hA5);
      issue(OP_RD_MEM, 4'h0, 12'hFFF, 8'h00);
      issue(OP_RD_MEM, 4'h0, 12'h000, 8'hFF);
      issue(OP_SET_INDEX, 4'h0, 12'(MEM_BYTES - 3), 8'h00);
      issue(OP_BCD, 4'h0, 12'h000, 8'h00);
      issue(OP_SET_INDEX, 4'h0, 12'(MEM_BYTES - 2), 8'h00);
      issue(OP_BCD, 4'hF, 12'h000, 8'h00);
      issue(OP_STORE, 4'h1, 12'h000, 8'h00);
      issue(OP_STORE, 4'h2, 12'h000, 8'h00);
      issue(OP_LOAD, 4'h2, 12'h000, 8'h00);
      issue(OP_LOAD, 4'h1, 12'h000, 8'h00);
      issue(OP_FONT_ADDR, 4'h0, 12'h000, 8'h00);
      issue(OP_ADD_REG, 4'hF, 12'h000, 8'h00);
      issue(OP_SET_INDEX, 4'h0, 12'h000, 8'h00);
      issue(OP_STORE, 4'hF, 12'h000, 8'h00);
      issue(OP_LOAD, 4'hF, 12'h000, 8'h00);
      issue(OP_RD_MEM, 4'h0, 12'h00F, 8'h00);
      issue(FIRST_SPARE_CODE, any_reg(), any_addr(), any_byte());
      issue(LAST_SPARE_CODE, any_reg(), any_addr(), any_byte());
      issue(OP_RD_REG, 4'h1, 12'h000, 8'h00);

      // random sequences, mostly well formed
      while (issued < ITEM_TARGET) begin
         if (issued >= ITEM_TARGET - TAIL_ITEMS) idle_off <= 1'b1;
         else if ($urandom_range(0, 11) == 0) idle_off <= !idle_off;
         if (!climbed && issued >= ITEM_TARGET / 2) begin
            climbed = 1'b1;
            climb_index();
         end else begin
            case ($urandom_range(0, 9))
               // block move round trip
               0, 1, 2: begin
                  issue(OP_SET_INDEX, any_reg(), pick_index(), any_byte());
                  repeat ($urandom_range(0, 3)) issue(OP_WR_REG, any_reg(), any_addr(), any_byte());
                  x = any_reg();
                  issue(OP_STORE, x, any_addr(), any_byte());
                  if ($urandom_range(0, 1)) issue(OP_WR_REG, any_reg(), any_addr(), any_byte());
                  load_regs(4'($urandom_range(0, x)));
                  issue(OP_RD_REG, any_reg(), any_addr(), any_byte());
               end
               // decimal digits, sometimes read back
               3, 4: begin
                  x = any_reg();
                  issue(OP_WR_REG, x, any_addr(), any_byte());
                  issue(OP_SET_INDEX, any_reg(), pick_index(), any_byte());
                  issue(OP_BCD, x, any_addr(), any_byte());
                  if ($urandom_range(0, 1)) begin
                     wait_for_results();
                     for (int k = 0; k < BCD_DIGITS; k++)
                        if (last_index + k < MEM_BYTES && mem_written[last_index + k])
                           issue(OP_RD_MEM, any_reg(), 12'(last_index + k), any_byte());
                  end
               end
               // glyph address and index arithmetic
               5: begin
                  x = any_reg();
                  issue(OP_WR_REG, x, any_addr(), any_byte());
                  issue(OP_FONT_ADDR, x, any_addr(), any_byte());
                  repeat ($urandom_range(1, 3)) issue(OP_ADD_REG, any_reg(), any_addr(), any_byte());
                  issue($urandom_range(0, 1) ? OP_STORE : OP_BCD, any_reg(), any_addr(), any_byte());
               end
               // direct memory bytes
               6: begin
                  issue(OP_WR_MEM, any_reg(), any_addr(), any_byte());
                  repeat ($urandom_range(1, 2)) read_mem();
               end
               // single random request of any code
               default: begin
                  code = 4'($urandom);
                  if (code == OP_LOAD) load_regs(any_reg());
                  else if (code == OP_RD_MEM) read_mem();
                  else issue(code, any_reg(), any_addr(), any_byte());
               end
            endcase
         end
      end

      // drain, settle, verdict
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);
      $display("%0d requests sent and %0d results returned over all request codes,",
               accepted_count, returned_count);
      $display("%0d refused past the memory end, with index wrap and idle/stall bursts",
               range_errors);
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
